// ===== rtl/bblur_pkg.sv =====
`timescale 1ns / 1ps

package bblur_pkg;

	// Frame geometry
	localparam int WIDTH_MAX = 1024;
	localparam int ROW_W = 16;
	localparam int COL_W = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
	localparam int EW = $clog2(WIDTH_MAX + 1);

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_WIDTH_W = 11;
	localparam int CFG_HEIGHT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

	// Input word kinds
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Pixel format: red in the low byte, then green, then blue
	localparam int CH_W = 8;
	localparam int CHANNELS = 3;
	localparam int PIX_W = CH_W * CHANNELS;

	// Results owed; at most width+1 held back plus one arriving
	localparam int PEND_W = $clog2(WIDTH_MAX + 3);

	// Pixel ring: the oldest neighbour is 2*width+2 words back
	localparam int RING_SPAN = 2 * WIDTH_MAX + 3;
	localparam int FILL_W = $clog2(RING_SPAN + 1);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int RING_AW = $clog2(RING_SPAN + WIDTH_MAX + QDEPTH + 8);
	localparam int RING_DEPTH = 2 ** RING_AW;
	localparam int AGE_W = $clog2(RING_SPAN) + 2;

	// Window arithmetic
	localparam int TAPS = 9;
	localparam int TAP_IDX_W = $clog2(TAPS);
	localparam int SUM_W = $clog2(TAPS * 255 + 1);
	localparam int NUM_W = SUM_W + 1;
	localparam int CNT_W = $clog2(TAPS + 1);
	localparam int DIV_W = CNT_W + 1;
	localparam int STEP_W = $clog2(CH_W);

	typedef struct packed {
		logic [TAPS-1:0]    mask;
		logic [PEND_W-1:0]  newest;
		logic [EW-1:0]      width;
		logic [RING_AW-1:0] wptr;
		logic [FILL_W-1:0]  fill;
		logic               frame_end;
	} job_t;

endpackage

// ===== rtl/bblur_ring.sv =====
`timescale 1ns / 1ps

module bblur_ring import bblur_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [RING_AW-1:0] waddr,
	input  logic [PIX_W-1:0]   wdata,
	input  logic               re,
	input  logic [RING_AW-1:0] raddr,
	output logic [PIX_W-1:0]   rdata
);

	logic [PIX_W-1:0] mem_q [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bblur_fifo.sv =====
`timescale 1ns / 1ps

module bblur_fifo import bblur_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	job_t           slots_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_job = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/bblur_front.sv =====
`timescale 1ns / 1ps

module bblur_front import bblur_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_valid,
	output logic                  s_ready,
	input  logic                  s_mode,
	input  logic [PIX_W-1:0]      s_pixel,
	input  logic                  q_full,
	output logic                  q_push,
	output job_t                  q_job,
	output logic                  ring_we,
	output logic [RING_AW-1:0]    ring_waddr,
	output logic [PIX_W-1:0]      ring_wdata
);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	function automatic pos_t advance(pos_t p, logic [EW-1:0] w, logic [ROW_W-1:0] h);
		pos_t         n;
		logic [EW:0]  c1;
		logic [ROW_W:0] r1;
		n = p;
		c1 = (EW+1)'(p.col) + (EW+1)'(1);
		r1 = (ROW_W+1)'(p.row) + (ROW_W+1)'(1);
		if (c1 >= (EW+1)'(w)) begin
			n.col = '0;
			if (r1 >= (ROW_W+1)'(h)) begin
				n.row = '0;
			end else begin
				n.row = r1[ROW_W-1:0];
			end
		end else begin
			n.col = c1[COL_W-1:0];
		end
		return n;
	endfunction

	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	pos_t                    out_pos_q;
	logic [PEND_W-1:0]       pending_q;
	logic [RING_AW-1:0]      wptr_q;
	logic [FILL_W-1:0]       fill_q;

	logic [EW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;
	logic             accept;
	logic             is_pixel;
	logic             emit;
	logic [FILL_W-1:0] fill_next;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;

	assign cfg_ready = 1'b1;
	assign s_ready = !q_full;
	assign accept = s_valid && s_ready;
	assign is_pixel = (s_mode == MODE_PIXEL);

	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (width_q > CFG_WIDTH_W'(WIDTH_MAX)) begin
			w_eff = EW'(WIDTH_MAX);
		end else begin
			w_eff = EW'(width_q);
		end
		h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	// A pixel releases a result once more than width+1 are held back
	always_comb begin
		if (is_pixel) begin
			emit = accept && (pending_q > PEND_W'(w_eff));
		end else begin
			emit = accept && (pending_q != '0);
		end
		fill_next = fill_q;
		if (accept && is_pixel && fill_q != FILL_W'(RING_SPAN)) begin
			fill_next = fill_q + FILL_W'(1);
		end
	end

	// Which neighbours of the outgoing position lie inside the frame
	always_comb begin
		row_ok[0] = (out_pos_q.row != '0) &&
			((ROW_W+1)'(out_pos_q.row) <= (ROW_W+1)'(h_eff));
		row_ok[1] = out_pos_q.row < h_eff;
		row_ok[2] = ((ROW_W+1)'(out_pos_q.row) + (ROW_W+1)'(1)) < (ROW_W+1)'(h_eff);
		col_ok[0] = (out_pos_q.col != '0) &&
			((EW+1)'(out_pos_q.col) <= (EW+1)'(w_eff));
		col_ok[1] = (EW+1)'(out_pos_q.col) < (EW+1)'(w_eff);
		col_ok[2] = ((EW+1)'(out_pos_q.col) + (EW+1)'(1)) < (EW+1)'(w_eff);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q_job.mask[r*3 + c] = row_ok[r] && col_ok[c];
			end
		end
		q_job.newest = is_pixel ? pending_q : pending_q - PEND_W'(1);
		q_job.width = w_eff;
		q_job.wptr = is_pixel ? wptr_q + RING_AW'(1) : wptr_q;
		q_job.fill = fill_next;
		q_job.frame_end = (out_pos_q.row == h_eff - ROW_W'(1)) &&
			(EW'(out_pos_q.col) == w_eff - EW'(1));
	end

	assign q_push = emit;
	assign ring_we = accept && is_pixel;
	assign ring_waddr = wptr_q;
	assign ring_wdata = s_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			out_pos_q <= '0;
			pending_q <= '0;
			wptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH: width_q <= cfg_data[CFG_WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (accept && is_pixel) begin
				wptr_q <= wptr_q + RING_AW'(1);
			end
			fill_q <= fill_next;
			if (emit) begin
				out_pos_q <= advance(out_pos_q, w_eff, h_eff);
			end
			if (accept && is_pixel && !emit) begin
				pending_q <= pending_q + PEND_W'(1);
			end else if (accept && !is_pixel && emit) begin
				pending_q <= pending_q - PEND_W'(1);
			end
		end
	end

endmodule

// ===== rtl/bblur_back.sv =====
`timescale 1ns / 1ps

module bblur_back import bblur_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  job_t               q_job,
	output logic               ring_re,
	output logic [RING_AW-1:0] ring_raddr,
	input  logic [PIX_W-1:0]   ring_rdata,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [PIX_W-1:0]   m_pixel,
	output logic               m_last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_GATHER = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_PREP   = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [1:0] TAP_LAST = 2'd2;

	logic [2:0]        state_q;
	job_t              job_q;
	logic [1:0]        tap_r_q;
	logic [1:0]        tap_c_q;
	logic              tap_valid_s1;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  sum_q [CHANNELS];
	logic [CNT_W-1:0]  count_q;
	logic [NUM_W-1:0]  rem_q [CHANNELS];
	logic [CH_W-1:0]   quo_q [CHANNELS];
	logic [DIV_W-1:0]  divisor_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_pixel_q;
	logic              out_last_q;

	logic signed [AGE_W-1:0] row_off;
	logic signed [AGE_W-1:0] age;
	logic [TAP_IDX_W-1:0]    tap_idx;
	logic                    tap_ok;
	logic [NUM_W-1:0]        shifted;
	logic [CHANNELS-1:0]     fits;
	logic                    load;

	// Distance back in the stream of the current neighbour
	always_comb begin
		case (tap_r_q)
			2'd0: row_off = $signed(AGE_W'(job_q.width));
			2'd2: row_off = -$signed(AGE_W'(job_q.width));
			default: row_off = '0;
		endcase
		age = $signed(AGE_W'(job_q.newest)) + row_off + $signed(AGE_W'(1))
			- $signed(AGE_W'(tap_c_q));
		tap_idx = TAP_IDX_W'({1'b0, tap_r_q, 1'b0}) + TAP_IDX_W'(tap_r_q)
			+ TAP_IDX_W'(tap_c_q);
		tap_ok = job_q.mask[tap_idx] && !age[AGE_W-1] &&
			(age < $signed(AGE_W'(job_q.fill)));
	end

	assign ring_re = (state_q == ST_GATHER) && tap_ok;
	assign ring_raddr = job_q.wptr - RING_AW'(1) - age[RING_AW-1:0];
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign load = (state_q == ST_DONE) && (!out_valid_q || m_ready);

	always_comb begin
		shifted = NUM_W'(divisor_q) << step_q;
		for (int k = 0; k < CHANNELS; k++) begin
			fits[k] = rem_q[k] >= shifted;
		end
	end

	assign m_valid = out_valid_q;
	assign m_pixel = out_pixel_q;
	assign m_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_r_q <= '0;
			tap_c_q <= '0;
			tap_valid_s1 <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tap_valid_s1 <= ring_re;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_valid && m_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					tap_r_q <= '0;
					tap_c_q <= '0;
					if (!q_empty) begin
						state_q <= ST_GATHER;
					end
				end
				ST_GATHER: begin
					if (tap_c_q == TAP_LAST) begin
						tap_c_q <= '0;
						tap_r_q <= tap_r_q + 2'd1;
						if (tap_r_q == TAP_LAST) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						tap_c_q <= tap_c_q + 2'd1;
					end
				end
				ST_DRAIN: state_q <= ST_PREP;
				ST_PREP: begin
					step_q <= STEP_W'(CH_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			job_q <= q_job;
			count_q <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				sum_q[k] <= '0;
			end
		end
		// Read data lands in the cycle after its tap was issued
		if (tap_valid_s1) begin
			count_q <= count_q + CNT_W'(1);
			for (int k = 0; k < CHANNELS; k++) begin
				sum_q[k] <= sum_q[k] + SUM_W'(ring_rdata[k*CH_W +: CH_W]);
			end
		end
		if (state_q == ST_PREP) begin
			divisor_q <= {count_q, 1'b0};
			for (int k = 0; k < CHANNELS; k++) begin
				rem_q[k] <= {sum_q[k], 1'b0} + NUM_W'(count_q);
				quo_q[k] <= '0;
			end
		end
		// One quotient bit per channel per cycle, highest first
		if (state_q == ST_DIV) begin
			for (int k = 0; k < CHANNELS; k++) begin
				if (fits[k]) begin
					rem_q[k] <= rem_q[k] - shifted;
				end
				quo_q[k] <= {quo_q[k][CH_W-2:0], fits[k]};
			end
		end
		if (load) begin
			out_last_q <= job_q.frame_end;
			for (int k = 0; k < CHANNELS; k++) begin
				out_pixel_q[k*CH_W +: CH_W] <= (count_q == '0) ? '0 : quo_q[k];
			end
		end
	end

endmodule

// ===== rtl/box_blur_3x3_rgb.sv =====
// Results: each word may release one result, which leaves once the back end is free;
// a pixel releases the result of the pixel width+1 places before it, a flush word the oldest owed.
// The back end finishes one job, nine tap lookups in the pixel ring and an eight-step divider,
// before it takes the next; words that release no result go in one per cycle while the queue is not full.
// The four-entry job queue lets the input side run ahead of the back end.
// Reset: positions, counts, queue and handshakes clear at once; the pixel ring is not cleared.
`timescale 1ns / 1ps

module box_blur_3x3_rgb import bblur_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
	output logic                  m_axis_tlast   // frame_end
);

	job_t               push_job;
	job_t               head_job;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	logic               ring_we;
	logic [RING_AW-1:0] ring_waddr;
	logic [PIX_W-1:0]   ring_wdata;
	logic               ring_re;
	logic [RING_AW-1:0] ring_raddr;
	logic [PIX_W-1:0]   ring_rdata;

	bblur_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_mode     (s_axis_tuser),
		.s_pixel    (s_axis_tdata),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata)
	);

	bblur_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	bblur_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	bblur_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_job      (head_job),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_pixel    (m_axis_tdata),
		.m_last     (m_axis_tlast)
	);

endmodule

// ===== rtl/bblur_checker.sv =====
`timescale 1ns / 1ps

module bblur_checker import bblur_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [PIX_W-1:0] m_axis_tdata,
	input logic             m_axis_tlast
);

	localparam int OWED_W = $clog2(WIDTH_MAX + QDEPTH + 16) + 1;
	localparam int OWED_MAX = WIDTH_MAX + QDEPTH + 3;

	logic [OWED_W-1:0] owed_q;
	logic              pix_in;
	logic              res_out;

	assign pix_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_PIXEL);
	assign res_out = m_axis_tvalid && m_axis_tready;

	// Pixels taken whose result has not yet left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else if (pix_in && !res_out) begin
			owed_q <= owed_q + OWED_W'(1);
		end else if (res_out && !pix_in) begin
			owed_q <= owed_q - OWED_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> owed_q != '0)
		else $error("result offered with no pixel owed");

	assert property (@(posedge clk) disable iff (!arst_n)
		owed_q == '0 |-> s_axis_tready)
		else $error("input stalled with nothing owed");

	assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= OWED_W'(OWED_MAX))
		else $error("more results owed than the line and queue can hold");

endmodule

bind box_blur_3x3_rgb bblur_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== bench/box_blur_3x3_rgb_tb.sv =====
`timescale 1ns / 1ps

module box_blur_3x3_rgb_tb;
	import bblur_pkg::*;

	localparam int RING_LEN = 2 * WIDTH_MAX + 9;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD = 500;
	localparam int REPORT_CAP = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic             mode;
		logic [PIX_W-1:0] pix;
	} blur_word_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} blur_px_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata = '0;  // in_red, in_green, in_blue
	logic                  s_axis_tuser = MODE_PIXEL;  // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;  // out_red, out_green, out_blue
	logic                  m_axis_tlast;  // frame_end

	box_blur_3x3_rgb u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Blur state as seen from outside
	logic [PIX_W-1:0]        pixel_hist [RING_LEN];
	logic [CFG_WIDTH_W-1:0]  reg_width = WIDTH_RESET;
	logic [CFG_HEIGHT_W-1:0] reg_height = HEIGHT_RESET;
	int                      wr_slot = 0;
	int                      out_col = 0;
	int                      out_row = 0;
	int                      pend_cnt = 0;

	blur_word_t pixel_word_q [$];
	blur_px_t   blurred_q [$];
	int         pushed_words = 0;
	int         error_cnt = 0;
	int         idle_cycles = 0;
	bit         s_taken = 1'b0;
	bit         hold_request = 1'b0;
	bit         hold_done = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         rx_left = 0;
	int         hold_left = 0;
	bit         rx_on = 1'b0;

	task automatic flag_error(input string what);
		error_cnt++;
		if (error_cnt <= REPORT_CAP)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Average the in-frame neighbours of the oldest owed pixel and retire it
	task automatic blur_window(input int w, input int h);
		int sum_r, sum_g, sum_b, cnt, newest, age, nr, nc, dr, dc;
		logic [PIX_W-1:0] px;
		blur_px_t res;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		cnt = 0;
		newest = pend_cnt - 1;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				nr = out_row + dr;
				nc = out_col + dc;
				age = newest - (dr * w + dc);
				if (nr < 0 || nr >= h || nc < 0 || nc >= w)
					continue;
				if (age < 0 || age >= RING_LEN)
					continue;
				px = pixel_hist[(wr_slot + RING_LEN - 1 - age) % RING_LEN];
				sum_r += px[7:0];
				sum_g += px[15:8];
				sum_b += px[23:16];
				cnt++;
			end
		end
		res.red = (cnt == 0) ? '0 : CH_W'((2 * sum_r + cnt) / (2 * cnt));
		res.green = (cnt == 0) ? '0 : CH_W'((2 * sum_g + cnt) / (2 * cnt));
		res.blue = (cnt == 0) ? '0 : CH_W'((2 * sum_b + cnt) / (2 * cnt));
		res.frame_end = (out_row == h - 1) && (out_col == w - 1);
		blurred_q.push_back(res);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h)
				out_row = 0;
		end
		pend_cnt--;
	endtask

	task automatic blur_step(input logic mode, input logic [PIX_W-1:0] pix);
		int w, h;
		w = (reg_width == 0) ? 1 : ((reg_width > WIDTH_MAX) ? WIDTH_MAX : int'(reg_width));
		h = (reg_height == 0) ? 1 : int'(reg_height);
		if (mode == MODE_FLUSH) begin
			if (pend_cnt != 0)
				blur_window(w, h);
		end else begin
			pixel_hist[wr_slot] = pix;
			wr_slot = (wr_slot + 1) % RING_LEN;
			pend_cnt++;
			if (pend_cnt > w + 1)
				blur_window(w, h);
		end
	endtask

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] rand_pix();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	function automatic void push_word(input logic mode, input logic [PIX_W-1:0] pix);
		blur_word_t wd;
		wd.mode = mode;
		wd.pix = pix;
		pixel_word_q.push_back(wd);
		pushed_words++;
	endfunction

	task automatic push_pixels(input int n, input int flush_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < flush_pct)
				push_word(MODE_FLUSH, rand_pix());
			push_word(MODE_PIXEL, rand_pix());
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH)
			reg_width = data[CFG_WIDTH_W-1:0];
		else if (idx == REG_IMAGE_HEIGHT)
			reg_height = data[CFG_HEIGHT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		#1;
	endtask

	// Upper bits of the width word lie outside the register and are scrambled
	task automatic set_size(input int w, input int h);
		write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
	endtask

	// Wait for every word to go in, flush out what is owed, then let the back end settle
	task automatic drain_frames();
		int extra;
		do
			@(posedge clk) #1;
		while (pixel_word_q.size() != 0 || s_axis_tvalid);
		extra = pend_cnt + $urandom_range(1, 2);
		repeat (extra) push_word(MODE_FLUSH, rand_pix());
		do
			@(posedge clk) #1;
		while (pixel_word_q.size() != 0 || s_axis_tvalid || blurred_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		#1;
	endtask

	// Input side: bursts of words with random gaps
	always @(negedge clk) begin
		blur_word_t wd;
		if (!s_axis_tvalid || s_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pixel_word_q.size() != 0) begin
				wd = pixel_word_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= wd.pix;
				s_axis_tuser <= wd.mode;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		s_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			blur_step(s_axis_tuser, s_axis_tdata);
	end

	// Output side: own stall pattern, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_on = !rx_on;
				if (rx_on)
					rx_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
				else
					rx_left = $urandom_range(1, 12);
			end else begin
				rx_left--;
			end
			m_axis_tready <= rx_on;
		end
	end

	always @(posedge clk) begin
		blur_px_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (blurred_q.size() == 0) begin
				flag_error("result word with nothing owed");
			end else begin
				want = blurred_q.pop_front();
				if (m_axis_tdata[7:0] !== want.red)
					flag_error($sformatf("red got %0d want %0d", m_axis_tdata[7:0], want.red));
				if (m_axis_tdata[15:8] !== want.green)
					flag_error($sformatf("green got %0d want %0d", m_axis_tdata[15:8],
						want.green));
				if (m_axis_tdata[23:16] !== want.blue)
					flag_error($sformatf("blue got %0d want %0d", m_axis_tdata[23:16],
						want.blue));
				if (m_axis_tlast !== want.frame_end)
					flag_error($sformatf("frame_end got %b want %b", m_axis_tlast,
						want.frame_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int w, h, wd, hd;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		#1;

		// 3x3 frame of full and empty channels with a mixed centre pixel, flushed once in mid frame
		set_size(3, 3);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				push_word(MODE_PIXEL, 24'h00FF80);
			else
				push_word(MODE_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
			if (i == 4)
				push_word(MODE_FLUSH, rand_pix());
		end
		drain_frames();

		// zero sizes act as one: single-pixel frames
		set_size(0, 0);
		push_word(MODE_PIXEL, 24'hFFFFFF);
		push_word(MODE_PIXEL, 24'h000000);
		push_word(MODE_PIXEL, rand_pix());
		drain_frames();

		// back the block up with a long hold-off while words keep coming
		set_size(6, 5);
		push_pixels(60, 0);
		hold_request = 1'b1;
		drain_frames();

		write_reg(REG_SPARE, 16'($urandom));

		while (pushed_words < 500) begin
			case ($urandom_range(0, 3))
				0: w = 1;
				1: w = $urandom_range(2, 4);
				default: w = $urandom_range(5, 16);
			endcase
			h = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
			wd = (w == 1 && $urandom_range(0, 1) == 1) ? 0 : w;
			hd = (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h;
			set_size(wd, hd);
			push_pixels(w * h * $urandom_range(1, 3), ($urandom_range(0, 1) == 1) ? 0 : 6);
			drain_frames();
		end

		// widest setting, clamped to the line buffer; only the top row is ever reached
		set_size(2047, 65535);
		push_pixels(40, 0);
		drain_frames();

		if (blurred_q.size() != 0)
			flag_error("results still owed at the end");
		if (error_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
